// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the rotation matrix to quaternion unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmq assertion failed");
`define RMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmq assertion failed");
`else
`define RMQ_ASSERT_SAME(label, ante, cons)
`define RMQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/rmq_pkg.sv =====
// Types and constants of the rotation matrix to quaternion unit.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int SQ_STAGES = 16;
  localparam int DV_STAGES = 17;
  localparam logic signed [18:0] Q_ONE = 19'sd16384;

  typedef enum logic [1:0] {
    BR_W = 2'd0,
    BR_X = 2'd1,
    BR_Y = 2'd2,
    BR_Z = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } out_t;

  typedef struct packed {
    logic               valid;
    branch_t            br;
    logic               zero;
    logic signed [16:0] n0;
    logic signed [16:0] n1;
    logic signed [16:0] n2;
  } sq_side_t;

  typedef struct packed {
    logic        valid;
    branch_t     br;
    logic        zero;
    logic [14:0] own;
  } dv_side_t;

endpackage

// ===== hdl/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rmq_sqrt import rmq_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] rad,
  output logic [15:0] root
);

  logic [15:0] root_s [0:16];
  logic [17:0] rem_s  [0:16];
  logic [31:0] n_s    [0:16];

  assign root_s[0] = '0;
  assign rem_s[0]  = '0;
  assign n_s[0]    = {1'b0, rad};

  for (genvar k = 0; k < 16; k++) begin : g_stage
    logic [19:0] rem2;
    logic [19:0] trial;
    logic        ge;
    assign rem2  = {rem_s[k], n_s[k][31:30]};
    assign trial = {2'b00, root_s[k], 2'b01};
    assign ge    = rem2 >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        root_s[k+1] <= {root_s[k][14:0], ge};
        rem_s[k+1]  <= ge ? 18'(rem2 - trial) : rem2[17:0];
        n_s[k+1]    <= {n_s[k][29:0], 2'b00};
      end
    end
  end

  assign root = root_s[16];

endmodule

// ===== hdl/rmq_div.sv =====
// Pipelined signed Q2.14 divider with saturation, one quotient bit per stage.
`timescale 1ns / 1ps
module rmq_div import rmq_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [16:0] num,
  input  logic [16:0]        s,
  output logic signed [15:0] q
);

  logic [16:0] mag_in;
  logic [30:0] mag;
  logic        neg;
  logic        ovf;
  logic [16:0] sd;

  assign mag_in = num[16] ? 17'(-num) : num;

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= {mag_in, 14'b0};
      neg <= num[16];
      ovf <= {2'b00, mag_in, 14'b0} >= {s, 16'b0};
      sd  <= s;
    end
  end

  logic [16:0] rem_s [0:16];
  logic [15:0] lo_s  [0:16];
  logic [15:0] q_s   [0:16];
  logic [16:0] s_s   [0:16];
  logic        neg_s [0:16];
  logic        ovf_s [0:16];

  assign rem_s[0] = {2'b00, mag[30:16]};
  assign lo_s[0]  = mag[15:0];
  assign q_s[0]   = '0;
  assign s_s[0]   = sd;
  assign neg_s[0] = neg;
  assign ovf_s[0] = ovf;

  for (genvar k = 0; k < 16; k++) begin : g_stage
    logic [17:0] rem2;
    logic        ge;
    assign rem2 = {rem_s[k], lo_s[k][15]};
    assign ge   = rem2 >= {1'b0, s_s[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? 17'(rem2 - {1'b0, s_s[k]}) : rem2[16:0];
        lo_s[k+1]  <= {lo_s[k][14:0], 1'b0};
        q_s[k+1]   <= {q_s[k][14:0], ge};
        s_s[k+1]   <= s_s[k];
        neg_s[k+1] <= neg_s[k];
        ovf_s[k+1] <= ovf_s[k];
      end
    end
  end

  always_comb begin
    if (!neg_s[16]) begin
      q = (ovf_s[16] || q_s[16][15]) ? 16'sh7fff : signed'(q_s[16]);
    end else if (ovf_s[16] || q_s[16] > 16'h8000) begin
      q = 16'sh8000;
    end else begin
      q = signed'(16'(-q_s[16]));
    end
  end

endmodule

// ===== hdl/rotation_matrix_to_quaternion_unit.sv =====
// Pipeline stages from request accept to result valid: 1 decode, 16 sqrt, 17 divide, 1 out.
// Throughput: one request per cycle; every stage advances together unless a valid output is stalled.
// The square root and three dividers each resolve one bit per iteration stage; each divider adds an input register.
// Reset (rst, synchronous) clears all valid bits; no data flush is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic signed [18:0] e00, e11, e22, t, r;
  branch_t            br;

  assign e00 = 19'(in_data.m00);
  assign e11 = 19'(in_data.m11);
  assign e22 = 19'(in_data.m22);
  assign t   = e00 + e11 + e22;

  always_comb begin
    if (t > 0) begin
      br = BR_W;
      r  = t + Q_ONE;
    end else if (e00 > e11 && e00 > e22) begin
      br = BR_X;
      r  = Q_ONE + e00 - e11 - e22;
    end else if (e11 > e22) begin
      br = BR_Y;
      r  = Q_ONE + e11 - e00 - e22;
    end else begin
      br = BR_Z;
      r  = Q_ONE + e22 - e00 - e11;
    end
  end

  logic signed [16:0] d0, d1, d2, p0, p1, p2;
  assign d0 = 17'(in_data.m21) - 17'(in_data.m12);
  assign d1 = 17'(in_data.m02) - 17'(in_data.m20);
  assign d2 = 17'(in_data.m10) - 17'(in_data.m01);
  assign p0 = 17'(in_data.m01) + 17'(in_data.m10);
  assign p1 = 17'(in_data.m02) + 17'(in_data.m20);
  assign p2 = 17'(in_data.m12) + 17'(in_data.m21);

  sq_side_t dec_next;
  always_comb begin
    dec_next.valid = in_valid;
    dec_next.br    = br;
    dec_next.zero  = r <= 0;
    unique case (br)
      BR_W: begin
        dec_next.n0 = d0; dec_next.n1 = d1; dec_next.n2 = d2;
      end
      BR_X: begin
        dec_next.n0 = d0; dec_next.n1 = p0; dec_next.n2 = p1;
      end
      BR_Y: begin
        dec_next.n0 = d1; dec_next.n1 = p0; dec_next.n2 = p2;
      end
      default: begin
        dec_next.n0 = d2; dec_next.n1 = p1; dec_next.n2 = p2;
      end
    endcase
  end

  sq_side_t    dec;
  logic [30:0] dec_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec <= '0;
    end else if (adv) begin
      dec     <= dec_next;
      dec_rad <= (r > 0) ? {r[16:0], 14'b0} : '0;
    end
  end

  logic [15:0] root;
  rmq_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (dec_rad),
    .root (root)
  );

  sq_side_t sq_line [0:SQ_STAGES-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQ_STAGES; i++) sq_line[i] <= '0;
    end else if (adv) begin
      sq_line[0] <= dec;
      for (int i = 1; i < SQ_STAGES; i++) sq_line[i] <= sq_line[i-1];
    end
  end

  sq_side_t    sq_end;
  logic [16:0] s_val;
  assign sq_end = sq_line[SQ_STAGES-1];
  assign s_val  = {root, 1'b0};

  logic signed [15:0] q0, q1, q2;
  rmq_div u_div0 (.clk(clk), .en(adv), .num(sq_end.n0), .s(s_val), .q(q0));
  rmq_div u_div1 (.clk(clk), .en(adv), .num(sq_end.n1), .s(s_val), .q(q1));
  rmq_div u_div2 (.clk(clk), .en(adv), .num(sq_end.n2), .s(s_val), .q(q2));

  dv_side_t dv_line [0:DV_STAGES-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DV_STAGES; i++) dv_line[i] <= '0;
    end else if (adv) begin
      dv_line[0] <= '{valid: sq_end.valid, br: sq_end.br, zero: sq_end.zero,
                      own: root[15:1]};
      for (int i = 1; i < DV_STAGES; i++) dv_line[i] <= dv_line[i-1];
    end
  end

  dv_side_t           dv_end;
  logic signed [15:0] own;
  out_t               res;
  assign dv_end = dv_line[DV_STAGES-1];
  assign own    = signed'({1'b0, dv_end.own});

  always_comb begin
    unique case (dv_end.br)
      BR_W:    res = '{quat_x: q0,  quat_y: q1,  quat_z: q2,  quat_w: own};
      BR_X:    res = '{quat_x: own, quat_y: q1,  quat_z: q2,  quat_w: q0};
      BR_Y:    res = '{quat_x: q1,  quat_y: own, quat_z: q2,  quat_w: q0};
      default: res = '{quat_x: q1,  quat_y: q2,  quat_z: own, quat_w: q0};
    endcase
    if (dv_end.zero) res = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_end.valid;
      out_data  <= res;
    end
  end

  `RMQ_ASSERT_NEXT(a_zero_result, adv && dv_end.valid && dv_end.zero, out_data == '0)
  `RMQ_ASSERT_NEXT(a_own_w_nonneg, adv && dv_end.valid && !dv_end.zero && dv_end.br == BR_W, !out_data.quat_w[15])
  `RMQ_ASSERT_NEXT(a_frozen_when_stalled, !adv, $stable(dec.valid) && $stable(dv_end.valid))
  `RMQ_ASSERT_SAME(a_stall_source, in_stall, out_valid && out_stall)

endmodule
